@@ rtl/efs_pkg.sv @@
// ----------------------------------------------------------------------------
// efs_pkg
// Shared codes and control types for the earliest-free-server dispatcher.
// ----------------------------------------------------------------------------
package efs_pkg;

  // Operation codes carried in the low bits of the input beat
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_JOB   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } efs_op_t;

  // Dispatcher control states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_INSERT = 1'b1
  } efs_state_t;

  // Command broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic load;    // write rate into the cell holding ld_id
    logic clear;   // zero the free time
    logic insert;  // pop the head and insert the updated entry
    logic sort;    // one odd-even transposition step
    logic phase;   // which pairs compare in this step
  } efs_cmd_t;

  localparam int RATE_W = 8;
  localparam int SIZE_W = 8;
  localparam int CFG_W  = 4;
  localparam int OUT_T_W = 32;

endpackage

@@ rtl/efs_cell.sv @@
// ----------------------------------------------------------------------------
// efs_cell
// One slot of the sorted server queue: free time, server number and rate.
// ----------------------------------------------------------------------------
module efs_cell #(
  parameter int NUM_SERVERS = 8,
  parameter int TIME_BITS   = 32,
  parameter int IDX_W       = 3,
  parameter int CNT_W       = 4,
  parameter int CELL_ID     = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  efs_pkg::efs_cmd_t      cmd,
  input  logic [CNT_W-1:0]       act_cnt,
  input  logic [IDX_W-1:0]       ld_id,
  input  logic [7:0]             ld_rate,
  input  logic [TIME_BITS-1:0]   ins_time,
  input  logic [IDX_W-1:0]       ins_id,
  input  logic [7:0]             ins_rate,
  input  logic [TIME_BITS-1:0]   left_time,
  input  logic [IDX_W-1:0]       left_id,
  input  logic [7:0]             left_rate,
  input  logic                   left_swap,
  input  logic [TIME_BITS-1:0]   right_time,
  input  logic [IDX_W-1:0]       right_id,
  input  logic [7:0]             right_rate,
  input  logic                   right_ins_before,
  output logic [TIME_BITS-1:0]   time_q,
  output logic [IDX_W-1:0]       id_q,
  output logic [7:0]             rate_q,
  output logic                   ins_before,
  output logic                   swap_right
);
  import efs_pkg::*;

  localparam bit IS_FIRST = (CELL_ID == 0);
  localparam bit IS_LAST  = (CELL_ID == NUM_SERVERS - 1);
  localparam bit ODD_CELL = (CELL_ID % 2) == 1;

  logic [TIME_BITS-1:0] time_next;
  logic [IDX_W-1:0]     id_next;
  logic [7:0]           rate_next;
  logic                 ins_lt_right;
  logic                 pair_right;
  logic                 pair_left;

  // Queue order: active servers first, then by free time, then by number
  function automatic logic ahead_of(input logic [TIME_BITS-1:0] ta,
                                    input logic [IDX_W-1:0] ia,
                                    input logic [TIME_BITS-1:0] tb,
                                    input logic [IDX_W-1:0] ib,
                                    input logic [CNT_W-1:0] n);
    logic act_a;
    logic act_b;
    act_a = 32'(ia) < 32'(n);
    act_b = 32'(ib) < 32'(n);
    if (act_a != act_b) return act_a;
    if (ta != tb) return ta < tb;
    return ia < ib;
  endfunction

  assign ins_before = ahead_of(ins_time, ins_id, time_q, id_q, act_cnt);
  assign swap_right = IS_LAST ? 1'b0
                              : ahead_of(right_time, right_id, time_q, id_q, act_cnt);

  // Past the last cell the queue reads as empty
  assign ins_lt_right = IS_LAST ? 1'b1 : right_ins_before;
  assign pair_right   = !IS_LAST  && (ODD_CELL == cmd.phase);
  assign pair_left    = !IS_FIRST && (ODD_CELL != cmd.phase);

  // Next slot contents
  always_comb begin
    time_next = time_q;
    id_next   = id_q;
    rate_next = rate_q;
    if (cmd.insert) begin
      if (ins_lt_right) begin
        if (IS_FIRST || !ins_before) begin
          time_next = ins_time;
          id_next   = ins_id;
          rate_next = ins_rate;
        end
      end else begin
        time_next = right_time;
        id_next   = right_id;
        rate_next = right_rate;
      end
    end else if (cmd.sort) begin
      if (pair_right && swap_right) begin
        time_next = right_time;
        id_next   = right_id;
        rate_next = right_rate;
      end else if (pair_left && left_swap) begin
        time_next = left_time;
        id_next   = left_id;
        rate_next = left_rate;
      end
    end else begin
      if (cmd.clear) time_next = '0;
      if (cmd.load && id_q == ld_id) rate_next = ld_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q <= '0;
      id_q   <= IDX_W'(CELL_ID);
      rate_q <= '0;
    end else begin
      time_q <= time_next;
      id_q   <= id_next;
      rate_q <= rate_next;
    end
  end

endmodule

@@ rtl/earliest_free_server_dispatch_core.sv @@
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_core
// Job dispatcher that sends each job to the earliest free server.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry an operation: load a server rate, dispatch a
// job, or clear the schedule. Each job beat yields one output beat on m_axis
// with the chosen server, its new free time and the running makespan; load
// and clear beats yield nothing. The active server count is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle; the block itself does not enforce this. For a job, the accept edge
// registers rate times size; in the insert state, once the output register
// is free, the sum with the head's free time is registered and the head is
// reinserted into the sorted cell chain. Loads are accepted every cycle
// while idle with no sort running. A clear or a config write starts an
// odd-even transposition sort of the chain, with s_axis_tready low while it
// runs. Reset leaves all free times, rates and the makespan at zero, servers
// in ascending order and 8 servers active. A stalled receiver holds the
// output register; load, clear and unused beats are still taken meanwhile,
// and a job waits in its insert step until the output register frees.
module earliest_free_server_dispatch_core #(
  parameter int NUM_SERVERS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [4:2] server_index, [12:5] rate_value, [20:13] job_size
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] assigned_server, [34:3] finish_time, [66:35] makespan
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);
  import efs_pkg::*;

  localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W = $clog2(NUM_SERVERS + 1);

  // Input beat fields
  logic [1:0]  in_op;
  logic [2:0]  in_idx;
  logic [7:0]  in_rate;
  logic [7:0]  in_size;
  logic        in_beat;

  // Control
  efs_state_t           state, state_next;
  efs_cmd_t             cmd;
  logic [CNT_W-1:0]     sort_left;
  logic [CFG_W-1:0]     active_servers;
  logic [CNT_W-1:0]     act_cnt;
  logic [15:0]          prod_q;
  logic [TIME_BITS-1:0] makespan_q;
  logic                 commit;
  logic                 ld_ok;
  logic [IDX_W-1:0]     ld_id;

  // Reinsertion entry
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] t_new;
  logic [TIME_BITS-1:0] mk_new;

  // Output register
  logic                 out_valid;
  logic [2:0]           out_server;
  logic [TIME_BITS-1:0] out_finish;
  logic [TIME_BITS-1:0] out_mk;

  // Chain wiring
  logic [TIME_BITS-1:0] time_a   [NUM_SERVERS];
  logic [IDX_W-1:0]     id_a     [NUM_SERVERS];
  logic [7:0]           rate_a   [NUM_SERVERS];
  logic                 insb_a   [NUM_SERVERS];
  logic                 swap_a   [NUM_SERVERS];
  logic [TIME_BITS-1:0] l_time   [NUM_SERVERS];
  logic [IDX_W-1:0]     l_id     [NUM_SERVERS];
  logic [7:0]           l_rate   [NUM_SERVERS];
  logic                 l_swap   [NUM_SERVERS];
  logic [TIME_BITS-1:0] r_time   [NUM_SERVERS];
  logic [IDX_W-1:0]     r_id     [NUM_SERVERS];
  logic [7:0]           r_rate   [NUM_SERVERS];
  logic                 r_insb   [NUM_SERVERS];

  assign in_op   = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[4:2];
  assign in_rate = s_axis_tdata[12:5];
  assign in_size = s_axis_tdata[20:13];

  assign s_axis_tready = (state == ST_IDLE) && (sort_left == '0);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Clamp the configured count to 1..NUM_SERVERS
  always_comb begin
    if (active_servers == '0) act_cnt = CNT_W'(1);
    else if (32'(active_servers) > NUM_SERVERS) act_cnt = CNT_W'(NUM_SERVERS);
    else act_cnt = CNT_W'(active_servers);
  end

  assign ld_ok = 32'(in_idx) < NUM_SERVERS;
  assign ld_id = IDX_W'(in_idx);

  // Saturating update of the head server
  assign sum    = {1'b0, time_a[0]} + {1'b0, TIME_BITS'(prod_q)};
  assign t_new  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign mk_new = (t_new > makespan_q) ? t_new : makespan_q;

  assign commit = (state == ST_INSERT) && (!out_valid || m_axis_tready);

  // Next state and cell commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sort   = (sort_left != '0);
    cmd.phase  = sort_left[0];
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          case (efs_op_t'(in_op))
            OP_LOAD:  cmd.load = ld_ok;
            OP_JOB:   state_next = ST_INSERT;
            OP_CLEAR: cmd.clear = 1'b1;
            default:  ;
          endcase
        end
      end
      ST_INSERT: begin
        if (commit) begin
          cmd.insert = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sort counter, active count and makespan
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_left      <= '0;
      active_servers <= CFG_W'(8);
      makespan_q     <= '0;
    end else begin
      if (sort_left != '0) sort_left <= sort_left - CNT_W'(1);
      if (cfg_wr_en) begin
        active_servers <= cfg_wr_data;
        sort_left      <= CNT_W'(NUM_SERVERS);
      end
      if (cmd.clear) begin
        makespan_q <= '0;
        sort_left  <= CNT_W'(NUM_SERVERS);
      end
      if (commit) makespan_q <= mk_new;
    end
  end

  // Work product of the head server, taken on the job beat
  always_ff @(posedge clk) begin
    if (in_beat && in_op == OP_JOB) prod_q <= 16'(rate_a[0]) * 16'(in_size);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_server <= 3'(id_a[0]);
      out_finish <= t_new;
      out_mk     <= mk_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, OUT_T_W'(out_mk), OUT_T_W'(out_finish), out_server};

  // Neighbor links; the ends see an empty slot
  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      l_time[i] = '0;
      l_id[i]   = '0;
      l_rate[i] = '0;
      l_swap[i] = 1'b0;
      r_time[i] = '0;
      r_id[i]   = '0;
      r_rate[i] = '0;
      r_insb[i] = 1'b1;
      if (i > 0) begin
        l_time[i] = time_a[i-1];
        l_id[i]   = id_a[i-1];
        l_rate[i] = rate_a[i-1];
        l_swap[i] = swap_a[i-1];
      end
      if (i < NUM_SERVERS - 1) begin
        r_time[i] = time_a[i+1];
        r_id[i]   = id_a[i+1];
        r_rate[i] = rate_a[i+1];
        r_insb[i] = insb_a[i+1];
      end
    end
  end

  // Row of queue cells, head at slot 0
  for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_cell
    efs_cell #(
      .NUM_SERVERS (NUM_SERVERS),
      .TIME_BITS   (TIME_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W),
      .CELL_ID     (g)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .cmd              (cmd),
      .act_cnt          (act_cnt),
      .ld_id            (ld_id),
      .ld_rate          (in_rate),
      .ins_time         (t_new),
      .ins_id           (id_a[0]),
      .ins_rate         (rate_a[0]),
      .left_time        (l_time[g]),
      .left_id          (l_id[g]),
      .left_rate        (l_rate[g]),
      .left_swap        (l_swap[g]),
      .right_time       (r_time[g]),
      .right_id         (r_id[g]),
      .right_rate       (r_rate[g]),
      .right_ins_before (r_insb[g]),
      .time_q           (time_a[g]),
      .id_q             (id_a[g]),
      .rate_q           (rate_a[g]),
      .ins_before       (insb_a[g]),
      .swap_right       (swap_a[g])
    );
  end

endmodule

@@ rtl/efs_checker.sv @@
// ----------------------------------------------------------------------------
// efs_checker
// Port-level checks for the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module efs_checker #(
  parameter int TIME_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        cfg_wr_en
);
  import efs_pkg::*;

  // A job beat keeps the input closed for its insert step
  a_job_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_JOB) |=> !s_axis_tready)
    else $error("input ready right after a job beat");

  // A new result only follows an insert step, when input was closed
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result beat without a job");

  // Config write starts a resort, input closed
  a_cfg_sort: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !s_axis_tready)
    else $error("input ready during resort");

  // Finish time never exceeds the makespan
  a_mk: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (TIME_BITS > 32) || (m_axis_tdata[34:3] <= m_axis_tdata[66:35]))
    else $error("finish time above makespan");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind earliest_free_server_dispatch_core efs_checker #(.TIME_BITS(TIME_BITS)) u_efs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_wr_en     (cfg_wr_en)
);
